/* src/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ffa_pkg.sv */
// Types and constants of the first-fit heap allocator.
`default_nettype none

package ffa_pkg;

    localparam int TYPE_W   = 2;
    localparam int SIZE_W   = 13;
    localparam int ADDR_W   = 13;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 13;
    localparam int OFS_W    = 16;

    localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 13'd4096;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_NOFIT   = 3'd1,
        STAT_CORRUPT = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_RANGE   = 3'd4,
        STAT_SMALL   = 3'd5
    } status_t;

    typedef enum logic {
        ALU_ADD_HDR = 1'b0,
        ALU_SUB_HDR = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [OFS_W:0] y;
        logic           neg;
        logic           pos;
    } alu_res_t;

    typedef struct packed {
        logic              valid;
        logic              free;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
    } done_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_ASPL,
        S_AFIN,
        S_FRD,
        S_FCHK,
        S_FRD2,
        S_FMRG,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/ffa_if.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none

interface ffa_req_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] address;

    modport source (output valid, req_type, alloc_size, address, input ready);
    modport sink (input valid, req_type, alloc_size, address, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;

    modport source (output valid, status, result_address, input ready);
    modport sink (input valid, status, result_address, output ready);
endinterface

`default_nettype wire

/* src/ffa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/ffa_alu.sv */
// Shared offset adder/subtractor with the header size folded in.
`default_nettype none

module ffa_alu #(
    parameter int HEADER_BYTES = 24
) (
    input  wire ffa_pkg::alu_op_t              op,
    input  wire logic [ffa_pkg::OFS_W-1:0]     a,
    input  wire logic [ffa_pkg::OFS_W-1:0]     b,
    output      ffa_pkg::alu_res_t             res
);
    import ffa_pkg::*;

    logic [OFS_W:0] ea;
    logic [OFS_W:0] eb;
    logic [OFS_W:0] eh;
    logic [OFS_W:0] y;

    assign ea = {1'b0, a};
    assign eb = {1'b0, b};
    assign eh = (OFS_W + 1)'(HEADER_BYTES);

    always_comb
    begin
        unique case (op)
            ALU_ADD_HDR: y = ea + eb + eh;
            ALU_SUB_HDR: y = ea - eb - eh;
            default:     y = '0;
        endcase
    end

    assign res.y   = y;
    assign res.neg = y[OFS_W];
    assign res.pos = !y[OFS_W] && (y != '0);

endmodule

`default_nettype wire

/* src/ffa_seq.sv */
// Allocator sequencer: clear sweep, init, header walk, split, free and merge over the header RAM.
`default_nettype none
`include "assert_macros.svh"

module ffa_seq #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ffa_req_if.sink                          req,
    input  wire logic [ffa_pkg::CFG_W-1:0]   heap_size,
    output      ffa_pkg::done_t              done,
    input  wire logic                        done_ready
);
    import ffa_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);

    function automatic logic in_heap(input logic [OFS_W-1:0] x);
        in_heap = 32'(x) < 32'(HEAP_BYTES);
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [OFS_W-1:0]  cur_reg, cur_next;
    logic [OFS_W-1:0]  nx_reg, nx_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] req_size_reg, req_size_next;
    logic [CFG_W-1:0]  heap_end_reg, heap_end_next;
    logic              list_set_reg, list_set_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;

    logic              ram_we;
    logic [OFS_W-1:0]  wr_ofs;
    hdr_t              ram_wdata;
    logic              ram_re;
    logic [OFS_W-1:0]  rd_ofs;
    logic [$bits(hdr_t)-1:0] ram_rdata;
    hdr_t              rd_hdr;

    alu_op_t           alu_op;
    logic [OFS_W-1:0]  alu_a;
    logic [OFS_W-1:0]  alu_b;
    alu_res_t          alu_res;
    logic [OFS_W-1:0]  alu_ofs;

    logic              in_fire;
    logic              init_range_bad;
    logic              fit;

    assign rd_hdr         = hdr_t'(ram_rdata);
    assign alu_ofs        = alu_res.y[OFS_W-1:0];
    assign in_fire        = req.valid && req.ready;
    assign init_range_bad = (heap_size == '0) || (32'(heap_size) > 32'(HEAP_BYTES));
    assign fit            = rd_hdr.free && (rd_hdr.size >= req_size_reg);

    ffa_alu #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    ffa_ram #(
        .WIDTH($bits(hdr_t)),
        .DEPTH(HEAP_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(wr_ofs)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(rd_ofs)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(HEAP_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type_t'(req.req_type))
                        REQ_ALLOC: state_next = list_set_reg ? S_ARD : S_DONE;
                        REQ_FREE:
                        begin
                            if (req.address == '0 || alu_res.neg || !in_heap(alu_ofs))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        REQ_INIT: state_next = S_DONE;
                        REQ_NONE: state_next = S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_ARD:  state_next = in_heap(cur_reg) ? S_ACHK : S_DONE;
            S_ACHK:
            begin
                if (!rd_hdr.valid)
                begin
                    state_next = S_DONE;
                end
                else if (fit)
                begin
                    state_next = alu_res.pos ? S_ASPL : S_AFIN;
                end
                else if (alu_ofs >= OFS_W'(heap_end_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_ASPL: state_next = S_AFIN;
            S_AFIN: state_next = S_DONE;
            S_FRD:  state_next = S_FCHK;
            S_FCHK:
            begin
                if (rd_hdr.valid && alu_ofs < OFS_W'(heap_end_reg) && in_heap(alu_ofs))
                begin
                    state_next = S_FRD2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FRD2: state_next = S_FMRG;
            S_FMRG: state_next = S_DONE;
            S_DONE:
            begin
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        wr_ofs    = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        rd_ofs    = '0;
        alu_op    = ALU_ADD_HDR;
        alu_a     = '0;
        alu_b     = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                wr_ofs = OFS_W'(clr_cnt_reg);
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                alu_op    = ALU_SUB_HDR;
                if (req_type_t'(req.req_type) == REQ_INIT)
                begin
                    alu_a = OFS_W'(heap_size);
                end
                else
                begin
                    alu_a = OFS_W'(req.address);
                end
                if (req.valid && req_type_t'(req.req_type) == REQ_INIT && !init_range_bad
                    && !alu_res.neg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{valid: 1'b1, free: 1'b1, size: alu_res.y[SIZE_W-1:0]};
                end
            end
            S_ARD:
            begin
                ram_re = in_heap(cur_reg);
                rd_ofs = cur_reg;
            end
            S_ACHK:
            begin
                if (fit)
                begin
                    alu_op = ALU_SUB_HDR;
                    alu_a  = OFS_W'(rd_hdr.size);
                    alu_b  = OFS_W'(req_size_reg);
                end
                else
                begin
                    alu_a = cur_reg;
                    alu_b = OFS_W'(rd_hdr.size);
                end
            end
            S_ASPL:
            begin
                alu_a     = cur_reg;
                alu_b     = OFS_W'(req_size_reg);
                ram_we    = in_heap(alu_ofs);
                wr_ofs    = alu_ofs;
                ram_wdata = '{valid: 1'b1, free: 1'b1, size: rem_reg};
            end
            S_AFIN:
            begin
                alu_a     = cur_reg;
                ram_we    = 1'b1;
                wr_ofs    = cur_reg;
                ram_wdata = '{valid: 1'b1, free: 1'b0, size: sz_reg};
            end
            S_FRD:
            begin
                ram_re = 1'b1;
                rd_ofs = cur_reg;
            end
            S_FCHK:
            begin
                alu_a     = cur_reg;
                alu_b     = OFS_W'(rd_hdr.size);
                ram_we    = rd_hdr.valid;
                wr_ofs    = cur_reg;
                ram_wdata = '{valid: 1'b1, free: 1'b1, size: rd_hdr.size};
            end
            S_FRD2:
            begin
                ram_re = 1'b1;
                rd_ofs = nx_reg;
            end
            S_FMRG:
            begin
                alu_a     = OFS_W'(sz_reg);
                alu_b     = OFS_W'(rd_hdr.size);
                ram_we    = rd_hdr.free;
                wr_ofs    = cur_reg;
                ram_wdata = '{valid: 1'b1, free: 1'b1, size: alu_res.y[SIZE_W-1:0]};
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign done.valid          = (state_reg == S_DONE);
    assign done.status         = status_reg;
    assign done.result_address = res_addr_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        nx_next       = nx_reg;
        sz_next       = sz_reg;
        rem_next      = rem_reg;
        req_size_next = req_size_reg;
        heap_end_next = heap_end_reg;
        list_set_next = list_set_reg;
        status_next   = status_reg;
        res_addr_next = res_addr_reg;
        case (state_reg)
            S_CLEAR: clr_cnt_next = clr_cnt_reg + 1'b1;
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_size_next = req.alloc_size;
                    res_addr_next = '0;
                    case (req_type_t'(req.req_type))
                        REQ_ALLOC:
                        begin
                            cur_next    = '0;
                            status_next = STAT_NOFIT;
                        end
                        REQ_FREE:
                        begin
                            cur_next    = alu_ofs;
                            status_next = (req.address == '0) ? STAT_IGNORED : STAT_CORRUPT;
                        end
                        REQ_INIT:
                        begin
                            if (init_range_bad)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                heap_end_next = heap_size;
                                if (alu_res.neg)
                                begin
                                    status_next = STAT_SMALL;
                                end
                                else
                                begin
                                    status_next   = STAT_OK;
                                    list_set_next = 1'b1;
                                end
                            end
                        end
                        default: status_next = STAT_IGNORED;
                    endcase
                end
            end
            S_ARD:
            begin
                if (!in_heap(cur_reg))
                begin
                    status_next = STAT_CORRUPT;
                end
            end
            S_ACHK:
            begin
                if (!rd_hdr.valid)
                begin
                    status_next = STAT_CORRUPT;
                end
                else if (fit)
                begin
                    sz_next  = alu_res.pos ? req_size_reg : rd_hdr.size;
                    rem_next = alu_res.y[SIZE_W-1:0];
                end
                else
                begin
                    cur_next    = alu_ofs;
                    status_next = STAT_NOFIT;
                end
            end
            S_AFIN:
            begin
                status_next   = STAT_OK;
                res_addr_next = alu_res.y[ADDR_W-1:0];
            end
            S_FCHK:
            begin
                if (rd_hdr.valid)
                begin
                    status_next = STAT_OK;
                    sz_next     = rd_hdr.size;
                    nx_next     = alu_ofs;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            heap_end_reg <= '0;
            list_set_reg <= 1'b0;
            status_reg   <= STAT_OK;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            heap_end_reg <= heap_end_next;
            list_set_reg <= list_set_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        nx_reg       <= nx_next;
        sz_reg       <= sz_next;
        rem_reg      <= rem_next;
        req_size_reg <= req_size_next;
        res_addr_reg <= res_addr_next;
    end

    `ASSERT_IMPL(a_rd_in_heap, ram_re, 32'(rd_ofs) < 32'(HEAP_BYTES), "read outside heap")
    `ASSERT_IMPL(a_no_wr_done, state_reg == S_DONE || (state_reg == S_IDLE && !in_fire),
        !ram_we, "header write while no item in work")
    `ASSERT_IMPL(a_fail_addr, state_reg == S_DONE && status_reg != STAT_OK,
        res_addr_reg == '0, "address given with a failing status")
    `ASSERT_IMPL(a_list_set, $rose(list_set_reg),
        $past(in_fire) && $past(req.req_type) == REQ_INIT, "heap set up without an init")
    `ASSERT_NEXT(a_busy, in_fire, !req.ready, "item taken while another is in work")

endmodule

`default_nettype wire

/* src/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator: config register, sequencer, response register.
//
// Usage:
//   req channel (valid/ready): req_type 0 allocates alloc_size bytes, 1 frees the block
//   at user offset address, 2 lays down one free block over heap_size bytes.
//   rsp channel (valid/ready): one item per request, status and result_address.
//   cfg_wr_en/cfg_wr_data write heap_size; write only while no request is in flight.
// Timing:
//   After reset the header RAM is swept clear, one entry a cycle, over all HEAP_BYTES
//   entries; req.ready stays low meanwhile. Init, type 3 and rejected requests go
//   straight to the response register. A free reads its header, checks it and marks
//   it free, then reads the next header when that lies in the heap and merges it if
//   it is free. An allocate walks the headers, each one visited costing one RAM read
//   and one check by the shared adder, then marks a fit, splitting it first when room
//   is left. The next request is taken in the cycle after the response is queued.
// Backpressure:
//   The response register holds one item; the next request is still accepted while
//   it waits, and the sequencer holds its finished result until the register frees.
`default_nettype none

module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [ffa_pkg::CFG_W-1:0] cfg_wr_data,
    ffa_req_if.sink                        req,
    ffa_rsp_if.source                      rsp
);
    import ffa_pkg::*;

    logic [CFG_W-1:0]    heap_size_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    done_t               done;
    logic                done_ready;

    assign done_ready = !out_valid_reg || rsp.ready;

    ffa_seq #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .heap_size  (heap_size_reg),
        .done       (done),
        .done_ready (done_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= HEAP_SIZE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                heap_size_reg <= cfg_wr_data;
            end
            if (done.valid && done_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.valid && done_ready)
        begin
            out_status_reg <= done.status;
            out_addr_reg   <= done.result_address;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_address = out_addr_reg;

endmodule

`default_nettype wire
